>>> design/half_gates_garbler_unit_assert.svh
// assertion macros shared by the garbler files
`ifndef HALF_GATES_GARBLER_UNIT_ASSERT_SVH
`define HALF_GATES_GARBLER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HGG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("garbler assertion failed");

// antecedent implies consequent in the next cycle
`define HGG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("garbler assertion failed");

`endif

>>> design/hgg_pkg.sv
package hgg_pkg;

   localparam int WIRE_SLOTS = 4096;
   localparam int WIRE_IDX_W = $clog2(WIRE_SLOTS);
   localparam int CSR_IDX_W  = 8;
   localparam int AES_LANES  = 4;
   localparam int AES_ROUNDS = 10;

   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_INPUT = 2'd1;
   localparam logic [1:0] KIND_GATE  = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   localparam logic [1:0] CLS_XOR  = 2'd0;
   localparam logic [1:0] CLS_XNOR = 2'd1;

   localparam logic RES_ROWS  = 1'b0;
   localparam logic RES_LABEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_KEY_LO = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_KEY_HI = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_LO     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_HI     = 8'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_AES,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] wire_a;
      logic [11:0] wire_b;
      logic [11:0] wire_out;
      logic [1:0]  gate_class;
      logic        a_alpha;
      logic        b_alpha;
      logic        c_alpha;
      logic [63:0] value_lo;
      logic [63:0] value_hi;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] row0_lo;
      logic [63:0] row0_hi;
      logic [63:0] row1_lo;
      logic [63:0] row1_hi;
      logic [63:0] label_lo;
      logic [63:0] label_hi;
      logic        permute_bit;
   } rsp_type;

   typedef logic [AES_LANES-1:0][127:0] blk4_type;

   typedef struct packed {
      logic         start;
      logic [127:0] key;
   } aes_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] rnd);
      logic [7:0] r;
      case (rnd)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1b;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [127:0] r;
      r[7:0]   = k[7:0]   ^ SBOX[k[111:104]] ^ rc;
      r[15:8]  = k[15:8]  ^ SBOX[k[119:112]];
      r[23:16] = k[23:16] ^ SBOX[k[127:120]];
      r[31:24] = k[31:24] ^ SBOX[k[103:96]];
      for (int w = 1; w < 4; w++) begin
         r[32*w +: 32] = k[32*w +: 32] ^ r[32*(w-1) +: 32];
      end
      return r;
   endfunction

   // sub bytes, shift rows and (unless last) mix columns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4*c] = SBOX[s[8*(i + 4*((c + i) & 3)) +: 8]];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0  = t[4*c];
            a1  = t[4*c+1];
            a2  = t[4*c+2];
            a3  = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[8*i +: 8] = t[i];
      end
      return r;
   endfunction

   // hash input: each half shifted left by one, tweak in the low half
   function automatic logic [127:0] hash_in(input logic [127:0] x, input logic [63:0] tw);
      return {x[126:64], 1'b0, {x[62:0], 1'b0} ^ tw};
   endfunction

   function automatic logic [WIRE_IDX_W-1:0] slot_of(input logic [11:0] w);
      return WIRE_IDX_W'(w % WIRE_SLOTS);
   endfunction

endpackage

>>> design/hgg_label_ram.sv
module hgg_label_ram (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [hgg_pkg::WIRE_IDX_W-1:0] rd_addr_a,
   input  logic [hgg_pkg::WIRE_IDX_W-1:0] rd_addr_b,
   output logic [127:0]                  rd_data_a,
   output logic [127:0]                  rd_data_b,
   input  logic                          wr_en,
   input  logic [hgg_pkg::WIRE_IDX_W-1:0] wr_addr,
   input  logic [127:0]                  wr_data
);
   import hgg_pkg::*;

   logic [127:0] mem [WIRE_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

>>> design/hgg_aes_core.sv
`include "half_gates_garbler_unit_assert.svh"

module hgg_aes_core (
   input  logic                  clock,
   input  logic                  reset,
   input  hgg_pkg::aes_ctl_type  ctl,
   input  hgg_pkg::blk4_type     blk_in,
   output logic                  done,
   output hgg_pkg::blk4_type     blk_out
);
   import hgg_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [3:0]   round_ff, round_in;
   logic [127:0] rk_ff, rk_in;
   blk4_type     st_ff, st_in;

   // one round per cycle on all lanes, key schedule on the fly
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      round_in = round_ff;
      rk_in    = rk_ff;
      st_in    = st_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         round_in = 4'd1;
         rk_in    = ctl.key;
         for (int l = 0; l < AES_LANES; l++) begin
            st_in[l] = blk_in[l] ^ ctl.key;
         end
      end else if (busy_ff) begin
         rk_in = key_step(rk_ff, rcon(round_ff));
         for (int l = 0; l < AES_LANES; l++) begin
            st_in[l] = aes_round(st_ff[l], round_ff == 4'(AES_ROUNDS)) ^ rk_in;
         end
         round_in = round_ff + 4'd1;
         if (round_ff == 4'(AES_ROUNDS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      rk_ff <= rk_in;
      st_ff <= st_in;
   end

   assign done    = done_ff;
   assign blk_out = st_ff;

   `HGG_ASSERT_NOW(a_start_idle, clock, reset, ctl.start, !busy_ff)
   `HGG_ASSERT_NEXT(a_done_after_last, clock, reset,
      busy_ff && round_ff == 4'(AES_ROUNDS) && !ctl.start, done_ff && !busy_ff)
   `HGG_ASSERT_NOW(a_done_not_busy, clock, reset, done_ff, !busy_ff)

endmodule

>>> design/half_gates_garbler_unit.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | hgg_pkg::req_type
// rsp     | out       | rsp_valid/rsp_stall | hgg_pkg::rsp_type
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// xor/xnor gate: read, write back; output query: read, emit
// input label: read, aes, write back; and-like gate: read, aes, emit; begin: two aes passes
// the aes work runs on the 10-round iterative aes core, four lanes side by side
// a one-entry request buffer takes the next transaction while one is at work,
// and the result register frees the engine while a response waits under rsp_stall
// reset is synchronous; the label memory is not cleared
`include "half_gates_garbler_unit_assert.svh"

module half_gates_garbler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hgg_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hgg_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hgg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                      csr_data
);
   import hgg_pkg::*;

   state_type    state_ff, state_in;
   logic         hold_valid_ff, hold_valid_in;
   req_type      hold_ff;
   req_type      item_ff, item_in;
   logic [127:0] a_ff, a_in, b_ff, b_in;
   logic [127:0] offset_ff, offset_in;
   logic [63:0]  tw1_ff, tw1_in, tw2_ff, tw2_in;
   logic         pass_ff, pass_in;
   rsp_type      res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic [63:0]  hkey_lo_ff, hkey_hi_ff, seed_lo_ff, seed_hi_ff;

   // label memory ports
   logic                  rd_en;
   logic [WIRE_IDX_W-1:0] rd_addr_a, rd_addr_b;
   logic [127:0]          rd_data_a, rd_data_b;
   logic                  wr_en;
   logic [WIRE_IDX_W-1:0] wr_addr;
   logic [127:0]          wr_data;

   // aes engine
   aes_ctl_type aes_ctl;
   blk4_type    aes_blk_in, aes_blk_out;
   logic        aes_done;

   // half-gates combine terms
   logic         pa, pb;
   logic [127:0] h0, h1, h2, h3, r0, r1, c_lbl, x_lbl;

   hgg_label_ram u_ram (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   hgg_aes_core u_aes (
      .clock   (clock),
      .reset   (reset),
      .ctl     (aes_ctl),
      .blk_in  (aes_blk_in),
      .done    (aes_done),
      .blk_out (aes_blk_out)
   );

   assign req_stall = hold_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;   // writes must only arrive while idle; the block does not enforce it

   // half-gates garbling of the four hashes
   always_comb begin
      pa    = a_ff[0];
      pb    = b_ff[0];
      h0    = aes_blk_out[0] ^ hash_in(a_ff, tw1_ff);
      h1    = aes_blk_out[1] ^ hash_in(a_ff ^ offset_ff, tw1_ff);
      h2    = aes_blk_out[2] ^ hash_in(b_ff, tw2_ff);
      h3    = aes_blk_out[3] ^ hash_in(b_ff ^ offset_ff, tw2_ff);
      r0    = h0 ^ h1 ^ ((item_ff.b_alpha ^ pb) ? offset_ff : '0);
      r1    = h2 ^ h3 ^ a_ff ^ (item_ff.a_alpha ? offset_ff : '0);
      c_lbl = (pa ? h1 : h0) ^ (pb ? h3 : h2)
            ^ ((((pa ^ item_ff.a_alpha) & (pb ^ item_ff.b_alpha)) ^ item_ff.c_alpha)
               ? offset_ff : '0);
      // free xor, offset added for xnor
      x_lbl = rd_data_a ^ rd_data_b ^ ((item_ff.gate_class == CLS_XNOR) ? offset_ff : '0);
   end

   always_comb begin
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      item_in       = item_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      offset_in     = offset_ff;
      tw1_in        = tw1_ff;
      tw2_in        = tw2_ff;
      pass_in       = pass_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr_a     = slot_of(hold_ff.wire_a);
      rd_addr_b     = slot_of(hold_ff.wire_b);
      wr_en         = 1'b0;
      wr_addr       = slot_of(item_ff.wire_out);
      wr_data       = c_lbl;
      aes_ctl.start = 1'b0;
      aes_ctl.key   = {hkey_hi_ff, hkey_lo_ff};
      aes_blk_in    = '0;

      if (req_valid && !req_stall) begin
         hold_valid_in = 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // launch label reads for the buffered transaction
            if (hold_valid_ff) begin
               rd_en         = 1'b1;
               item_in       = hold_ff;
               hold_valid_in = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            a_in = rd_data_a;
            b_in = rd_data_b;
            case (item_ff.kind)
               KIND_BEGIN: begin
                  aes_ctl.start = 1'b1;
                  aes_ctl.key   = {seed_hi_ff, seed_lo_ff};
                  pass_in       = 1'b0;
                  state_in      = ST_AES;
               end
               KIND_INPUT: begin
                  aes_ctl.start = 1'b1;
                  aes_ctl.key   = {seed_hi_ff, seed_lo_ff};
                  aes_blk_in[0] = {item_ff.value_hi, item_ff.value_lo};
                  state_in      = ST_AES;
               end
               KIND_QUERY: begin
                  res_in             = '0;
                  res_in.result_kind = RES_LABEL;
                  res_in.label_lo    = rd_data_a[63:0];
                  res_in.label_hi    = rd_data_a[127:64];
                  res_in.permute_bit = rd_data_a[0];
                  state_in           = ST_EMIT;
               end
               default: begin
                  if (item_ff.gate_class inside {CLS_XOR, CLS_XNOR}) begin
                     wr_en    = 1'b1;
                     wr_data  = x_lbl;
                     state_in = ST_IDLE;
                  end else begin
                     // four hashes at once, one lane each
                     aes_ctl.start = 1'b1;
                     aes_blk_in[0] = hash_in(rd_data_a, tw1_ff);
                     aes_blk_in[1] = hash_in(rd_data_a ^ offset_ff, tw1_ff);
                     aes_blk_in[2] = hash_in(rd_data_b, tw2_ff);
                     aes_blk_in[3] = hash_in(rd_data_b ^ offset_ff, tw2_ff);
                     state_in      = ST_AES;
                  end
               end
            endcase
         end
         ST_AES: begin
            if (aes_done) begin
               case (item_ff.kind)
                  KIND_BEGIN: begin
                     if (!pass_ff) begin
                        // second seed pass over the first result
                        aes_ctl.start = 1'b1;
                        aes_ctl.key   = {seed_hi_ff, seed_lo_ff};
                        aes_blk_in[0] = aes_blk_out[0];
                        pass_in       = 1'b1;
                     end else begin
                        offset_in = {aes_blk_out[0][127:1], 1'b1};
                        tw1_in    = '0;
                        tw2_in    = item_ff.value_lo;
                        state_in  = ST_IDLE;
                     end
                  end
                  KIND_INPUT: begin
                     wr_en    = 1'b1;
                     wr_addr  = slot_of(item_ff.wire_a);
                     wr_data  = aes_blk_out[0];
                     state_in = ST_IDLE;
                  end
                  default: begin
                     wr_en          = 1'b1;
                     res_in         = '0;
                     res_in.result_kind = RES_ROWS;
                     res_in.row0_lo = r0[63:0];
                     res_in.row0_hi = r0[127:64];
                     res_in.row1_lo = r1[63:0];
                     res_in.row1_hi = r1[127:64];
                     tw1_in         = tw1_ff + 64'd1;
                     tw2_in         = tw2_ff + 64'd1;
                     state_in       = ST_EMIT;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // hand over once the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         offset_ff     <= '0;
         tw1_ff        <= '0;
         tw2_ff        <= '0;
         pass_ff       <= 1'b0;
         hkey_lo_ff    <= '0;
         hkey_hi_ff    <= '0;
         seed_lo_ff    <= '0;
         seed_hi_ff    <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         offset_ff     <= offset_in;
         tw1_ff        <= tw1_in;
         tw2_ff        <= tw2_in;
         pass_ff       <= pass_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HASH_KEY_LO: hkey_lo_ff <= csr_data;
               CSR_HASH_KEY_HI: hkey_hi_ff <= csr_data;
               CSR_SEED_LO:     seed_lo_ff <= csr_data;
               CSR_SEED_HI:     seed_hi_ff <= csr_data;
               default:         ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hold_ff <= req_data;
      end
      item_ff <= item_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   `HGG_ASSERT_NOW(a_done_in_aes, clock, reset, aes_done, state_ff == ST_AES)
   `HGG_ASSERT_NOW(a_write_busy, clock, reset, wr_en,
      state_ff == ST_LOAD || state_ff == ST_AES)
   `HGG_ASSERT_NEXT(a_hold_kept, clock, reset,
      hold_valid_ff && state_ff != ST_IDLE, hold_valid_ff)
   `HGG_ASSERT_NEXT(a_emit_loads, clock, reset,
      state_ff == ST_EMIT && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff)

endmodule
